>>> rtl/iss_pkg.sv
`timescale 1ns / 1ps

package iss_pkg;

    localparam int MAX_ELEMENTS  = 256;
    localparam int INDEX_ENTRIES = 3;

    localparam int VAL_W   = 32;
    localparam int ADDR_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam int SLOT_W  = $clog2(INDEX_ENTRIES);
    localparam int SLOTC_W = $clog2(INDEX_ENTRIES + 1);
    localparam int STAT_W  = 2;
    localparam int POS_W   = 8;
    localparam int PRB_W   = 9;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic                    action;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [PRB_W-1:0]  probes;
    } t_res;

    typedef struct packed {
        logic load;
        logic key_cap;
        logic build_wr;
        logic sel;
        logic scan;
    } t_cmd;

    typedef struct packed {
        logic build_more;
        logic oor;
        logic scan_stop;
    } t_stat;

endpackage

>>> rtl/indexed_sequential_search.sv
`timescale 1ns / 1ps
// channel   ports                      beat
// -------   ------------------------   ------------------------------------
// item in   start, busy, i_item        start high while busy low
// result    o_done, o_res              o_done high for one cycle
//
// A load stores one element; the last load then also builds the index,
// reading each entry's key from the element memory.
// A search picks an index segment and scans it one probe per cycle through the
// element memory read port; the result strobes in the cycle after the search ends.
// Synchronous active-low reset empties the array and the index.
// The receiver cannot stall; a result holds on o_res until the next one.

module indexed_sequential_search (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  iss_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_done,
    output iss_pkg::t_res o_res
);
    import iss_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    iss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_last   (i_item.last),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    iss_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_res)
    );

endmodule

>>> rtl/iss_datapath.sv
`timescale 1ns / 1ps

module iss_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  iss_pkg::t_in  i_item,
    input  iss_pkg::t_cmd i_cmd,
    output iss_pkg::t_stat o_stat,
    output iss_pkg::t_res o_res
);
    import iss_pkg::*;

    logic signed [VAL_W-1:0] r_mem [MAX_ELEMENTS];
    logic signed [VAL_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]       rd_addr;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_spacing;
    logic [SLOT_W-1:0]       r_phase;
    logic                    r_open;
    logic signed [VAL_W-1:0] r_first;
    logic signed [VAL_W-1:0] r_last;
    logic signed [VAL_W-1:0] r_key;

    logic [CNT_W:0]          r_p;
    logic [SLOTC_W-1:0]      r_j;
    logic signed [VAL_W-1:0] r_idx_key  [INDEX_ENTRIES];
    logic [ADDR_W-1:0]       r_idx_pos  [INDEX_ENTRIES];
    logic [INDEX_ENTRIES-1:0] r_idx_used;

    logic [CNT_W-1:0]        r_k;
    logic [CNT_W-1:0]        r_begin;
    logic [CNT_W-1:0]        r_end;
    t_res                    r_res;

    logic [CNT_W-1:0]        base_count;
    logic [CNT_W-1:0]        base_spacing;
    logic [SLOT_W-1:0]       base_phase;
    logic                    store;
    logic [CNT_W-1:0]        n_count;
    logic [CNT_W-1:0]        n_spacing;
    logic [SLOT_W-1:0]       n_phase;

    logic [CNT_W-1:0]        seg_begin;
    logic [CNT_W-1:0]        seg_end;
    logic [CNT_W-1:0]        kp1;
    logic                    oor;
    logic                    scan_stop;

    // load bookkeeping: a load with no open array starts a new one
    always_comb begin
        base_count   = r_open ? r_count   : '0;
        base_spacing = r_open ? r_spacing : '0;
        base_phase   = r_open ? r_phase   : '0;
        store        = base_count < CNT_W'(MAX_ELEMENTS);
        n_count      = base_count;
        n_spacing    = base_spacing;
        n_phase      = base_phase;
        if (store) begin
            n_count = base_count + CNT_W'(1);
            if (base_phase == '0) begin
                n_spacing = base_spacing + CNT_W'(1);
            end
            if (base_phase == SLOT_W'(INDEX_ENTRIES - 1)) begin
                n_phase = '0;
            end else begin
                n_phase = base_phase + SLOT_W'(1);
            end
        end
    end

    // segment choice from the index table
    always_comb begin
        logic          chosen;
        logic [CNT_W-1:0] last_pos;
        chosen   = 1'b0;
        last_pos = '0;
        seg_begin = '0;
        seg_end   = r_count;
        for (int i = 0; i < INDEX_ENTRIES; i++) begin
            if (r_idx_used[i]) begin
                last_pos = CNT_W'(r_idx_pos[i]);
            end
        end
        for (int i = 0; i < INDEX_ENTRIES - 1; i++) begin
            if (!chosen && r_idx_used[i] && r_idx_key[i] <= r_key &&
                r_idx_used[i+1] && r_idx_key[i+1] > r_key) begin
                chosen    = 1'b1;
                seg_begin = CNT_W'(r_idx_pos[i]);
                seg_end   = CNT_W'(r_idx_pos[i+1]);
            end
        end
        if (!chosen) begin
            seg_begin = last_pos;
            seg_end   = r_count;
        end
    end

    assign oor       = r_open || (r_count == '0) || (r_key < r_first) || (r_key > r_last);
    assign kp1       = r_k + CNT_W'(1);
    assign scan_stop = (r_k >= r_end) || (r_rd_data >= r_key);

    always_comb begin
        priority if (i_cmd.sel) begin
            rd_addr = seg_begin[ADDR_W-1:0];
        end else if (i_cmd.scan) begin
            rd_addr = kp1[ADDR_W-1:0];
        end else begin
            rd_addr = r_p[ADDR_W-1:0];
        end
    end

    assign o_stat.build_more = (r_p < {1'b0, r_count}) &&
                               (r_j < SLOTC_W'(INDEX_ENTRIES));
    assign o_stat.oor        = oor;
    assign o_stat.scan_stop  = scan_stop;
    assign o_res             = r_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && store) begin
            r_mem[base_count[ADDR_W-1:0]] <= i_item.value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_spacing  <= '0;
            r_phase    <= '0;
            r_open     <= 1'b0;
            r_p        <= '0;
            r_j        <= '0;
            r_idx_used <= '0;
        end else begin
            if (i_cmd.load) begin
                r_count   <= n_count;
                r_spacing <= n_spacing;
                r_phase   <= n_phase;
                r_open    <= !i_item.last;
                if (!r_open || i_item.last) begin
                    r_idx_used <= '0;
                end
                if (i_item.last) begin
                    r_p <= '0;
                    r_j <= '0;
                end
            end
            if (i_cmd.build_wr) begin
                r_idx_used[r_j[SLOT_W-1:0]] <= 1'b1;
                r_p <= r_p + {1'b0, r_spacing};
                r_j <= r_j + SLOTC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && store) begin
            if (base_count == '0) begin
                r_first <= i_item.value;
            end
            r_last <= i_item.value;
        end
        if (i_cmd.key_cap) begin
            r_key <= i_item.value;
        end
        if (i_cmd.build_wr) begin
            r_idx_key[r_j[SLOT_W-1:0]] <= r_rd_data;
            r_idx_pos[r_j[SLOT_W-1:0]] <= r_p[ADDR_W-1:0];
        end
        if (i_cmd.sel) begin
            r_k     <= seg_begin;
            r_begin <= seg_begin;
            r_end   <= seg_end;
            if (oor) begin
                r_res.status   <= ST_RANGE;
                r_res.position <= '0;
                r_res.probes   <= '0;
            end
        end
        if (i_cmd.scan) begin
            if (scan_stop) begin
                r_res.status   <= ((r_k < r_end) && (r_rd_data == r_key)) ? ST_FOUND : ST_MISS;
                r_res.position <= POS_W'(r_k);
                r_res.probes   <= PRB_W'(r_k - r_begin + CNT_W'(1));
            end else begin
                r_k <= kp1;
            end
        end
    end

endmodule

>>> rtl/iss_ctrl.sv
`timescale 1ns / 1ps

module iss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_action,
    input  logic           i_last,
    input  iss_pkg::t_stat i_stat,
    output iss_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);
    import iss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BRD,
        S_BWR,
        S_SEL,
        S_SCAN
    } t_state;

    t_state r_state;
    logic   r_done;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == ACT_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.key_cap = 1'b1;
                    end
                end
            end
            S_BRD:  o_cmd = '0;
            S_BWR:  o_cmd.build_wr = 1'b1;
            S_SEL:  o_cmd.sel = 1'b1;
            S_SCAN: o_cmd.scan = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_action == ACT_SEARCH) begin
                            r_state <= S_SEL;
                        end else if (i_last) begin
                            r_state <= S_BRD;
                        end
                    end
                end
                S_BRD: begin
                    r_state <= i_stat.build_more ? S_BWR : S_IDLE;
                end
                S_BWR: begin
                    r_state <= S_BRD;
                end
                S_SEL: begin
                    if (i_stat.oor) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_stat.scan_stop) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/iss_checker.sv
`timescale 1ns / 1ps

module iss_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input iss_pkg::t_in  i_item,
    input logic          busy,
    input logic          o_done,
    input iss_pkg::t_res o_res
);
    import iss_pkg::*;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.status == ST_FOUND || o_res.status == ST_MISS ||
                    o_res.status == ST_RANGE))
        else $error("bad status code");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_RANGE) |->
            (o_res.position == '0 && o_res.probes == '0))
        else $error("out-of-range result with nonzero position or probes");

    a_found_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_FOUND) |-> (o_res.probes != '0))
        else $error("found result with zero probes");

    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == ACT_LOAD && !i_item.last) |=>
            (!busy && !o_done))
        else $error("plain load did not complete in one cycle");

endmodule

bind indexed_sequential_search iss_checker u_iss_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_item  (i_item),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);
